// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the ring modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define OLR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define OLR_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/olr_pkg.sv -----
package olr_pkg;

	localparam int LOG_DEPTH_DEF = 4096;
	localparam int MAX_READ_DEF  = 32;
	// capped read length and parked size
	localparam int WSIZE_W       = 6;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_READ,
		CMD_CANCEL,
		CMD_SELECT
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_STATUS,
		KIND_SEL_READY,
		KIND_SEL_NOTICE
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_AGAIN,
		ST_SUSPENDED,
		ST_INTR,
		ST_STALE
	} status_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  data_byte;
		logic        write_end;
		logic [15:0] requester;
		logic [31:0] req_id;
		logic [15:0] size;
		logic        nonblock;
		logic [3:0]  ops;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] dest;
		logic [31:0] reply_id;
		logic [7:0]  byte_out;
		status_t     status;
		logic [15:0] count;
		logic [2:0]  rdy_bits;
		logic        last;
	} beat_t;

endpackage

// ----- rtl/core/olr_ram.sv -----
module olr_ram #(
	parameter int DEPTH = olr_pkg::LOG_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata_q
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/olr_ctrl.sv -----
`include "assert_macros.svh"

module olr_ctrl #(
	parameter int LOG_DEPTH = olr_pkg::LOG_DEPTH_DEF,
	parameter int MAX_READ  = olr_pkg::MAX_READ_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  olr_pkg::item_t               item,
	input  logic                         stage_free,
	output logic                         push,
	output olr_pkg::beat_t               beat,
	output logic                         ram_we,
	output logic [$clog2(LOG_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                   ram_wdata,
	output logic                         ram_re,
	output logic [$clog2(LOG_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                   ram_rdata
);

	import olr_pkg::*;

	localparam int PTR_W  = $clog2(LOG_DEPTH);
	localparam int FILL_W = $clog2(LOG_DEPTH + 1);
	localparam int CMP_W  = (FILL_W > WSIZE_W) ? FILL_W : WSIZE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_ADDR,
		S_RD_DATA,
		S_POST,
		S_REPORT,
		S_REPLY
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [7:0]          data_q;
	logic                wend_q;
	logic [15:0]         who_q;
	logic [31:0]         rid_q;
	logic [WSIZE_W-1:0]  capped_q;
	logic                nonblock_q;
	logic [3:0]          ops_q;

	logic [PTR_W-1:0]    rptr_q;
	logic [PTR_W-1:0]    wptr_q;
	logic [FILL_W-1:0]   fill_q;
	logic                waiter_valid_q;
	logic [15:0]         waiter_who_q;
	logic [31:0]         waiter_id_q;
	logic [WSIZE_W-1:0]  waiter_size_q;
	logic [2:0]          sel_flags_q;
	logic [15:0]         sel_who_q;
	logic [15:0]         tally_q;

	logic [15:0]         drn_who_q;
	logic [31:0]         drn_rid_q;
	logic [WSIZE_W-1:0]  n_q;
	logic [WSIZE_W-1:0]  rem_q;
	logic                from_write_q;

	kind_t               rep_kind_q;
	status_t             rep_status_q;
	logic [2:0]          rep_ready_q;

	logic [WSIZE_W-1:0]  capped;
	logic                full;
	logic [FILL_W-1:0]   fill_eff;
	logic [WSIZE_W-1:0]  want;
	logic [WSIZE_W-1:0]  n_min;
	logic [2:0]          sel_ready;
	logic [2:0]          sel_left;
	logic                notice_due;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(LOG_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign capped = (item.size > 16'(MAX_READ)) ? WSIZE_W'(MAX_READ)
		: item.size[WSIZE_W-1:0];
	assign full = (fill_q == FILL_W'(LOG_DEPTH));

	// the one compare unit: min(wanted, bytes held)
	always_comb begin
		fill_eff = fill_q;
		want     = capped_q;
		if (cmd_q == CMD_WRITE) begin
			fill_eff = full ? fill_q : fill_q + 1'b1;
			want     = waiter_size_q;
		end
		n_min = (CMP_W'(fill_eff) < CMP_W'(want)) ? WSIZE_W'(fill_eff) : want;
	end

	assign sel_ready  = {1'b0, ops_q[1], ops_q[0] && (fill_q != '0)};
	assign sel_left   = ops_q[2:0] & ~sel_ready;
	assign notice_due = (fill_q != '0) && sel_flags_q[0];

	assign in_ready  = (state_q == S_IDLE);
	assign ram_we    = (state_q == S_EXEC) && (cmd_q == CMD_WRITE);
	assign ram_waddr = wptr_q;
	assign ram_wdata = data_q;
	assign ram_re    = (state_q == S_RD_ADDR);
	assign ram_raddr = rptr_q;

	always_comb begin
		push = 1'b0;
		beat = '0;
		unique case (state_q)
			S_REPLY: begin
				push          = stage_free;
				beat.kind     = rep_kind_q;
				beat.dest     = who_q;
				beat.reply_id = (rep_kind_q == KIND_SEL_READY) ? '0 : rid_q;
				beat.status   = rep_status_q;
				beat.rdy_bits = rep_ready_q;
				beat.last     = 1'b1;
			end
			S_RD_DATA: begin
				push          = stage_free;
				beat.kind     = KIND_DATA;
				beat.dest     = drn_who_q;
				beat.reply_id = drn_rid_q;
				beat.byte_out = ram_rdata;
				beat.count    = 16'(n_q);
				beat.last     = (rem_q == '0) && !from_write_q;
			end
			S_POST: begin
				push          = stage_free && notice_due;
				beat.kind     = KIND_SEL_NOTICE;
				beat.dest     = sel_who_q;
				beat.rdy_bits = 3'b001;
			end
			S_REPORT: begin
				push          = stage_free;
				beat.kind     = KIND_STATUS;
				beat.dest     = who_q;
				beat.reply_id = rid_q;
				beat.count    = tally_q;
				beat.last     = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cmd_q          <= CMD_WRITE;
			data_q         <= '0;
			wend_q         <= 1'b0;
			who_q          <= '0;
			rid_q          <= '0;
			capped_q       <= '0;
			nonblock_q     <= 1'b0;
			ops_q          <= '0;
			rptr_q         <= '0;
			wptr_q         <= '0;
			fill_q         <= '0;
			waiter_valid_q <= 1'b0;
			waiter_who_q   <= '0;
			waiter_id_q    <= '0;
			waiter_size_q  <= '0;
			sel_flags_q    <= '0;
			sel_who_q      <= '0;
			tally_q        <= '0;
			drn_who_q      <= '0;
			drn_rid_q      <= '0;
			n_q            <= '0;
			rem_q          <= '0;
			from_write_q   <= 1'b0;
			rep_kind_q     <= KIND_STATUS;
			rep_status_q   <= ST_OK;
			rep_ready_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q      <= item.cmd;
						data_q     <= item.data_byte;
						wend_q     <= item.write_end;
						who_q      <= item.requester;
						rid_q      <= item.req_id;
						capped_q   <= capped;
						nonblock_q <= item.nonblock;
						ops_q      <= item.ops;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					rep_kind_q   <= KIND_STATUS;
					rep_status_q <= ST_OK;
					rep_ready_q  <= '0;
					unique case (cmd_q)
						CMD_WRITE: begin
							wptr_q <= ptr_next(wptr_q);
							if (full) begin
								rptr_q <= ptr_next(rptr_q);
							end else begin
								fill_q <= fill_q + 1'b1;
							end
							if (tally_q != 16'hFFFF) begin
								tally_q <= tally_q + 1'b1;
							end
							if (!wend_q) begin
								state_q <= S_IDLE;
							end else if (waiter_valid_q) begin
								waiter_valid_q <= 1'b0;
								drn_who_q      <= waiter_who_q;
								drn_rid_q      <= waiter_id_q;
								n_q            <= n_min;
								rem_q          <= n_min;
								from_write_q   <= 1'b1;
								state_q        <= S_RD_ADDR;
							end else begin
								state_q <= S_POST;
							end
						end
						CMD_READ: begin
							if (waiter_valid_q) begin
								state_q <= S_REPLY;
							end else if (fill_q == '0 && capped_q != '0) begin
								if (nonblock_q) begin
									rep_status_q <= ST_AGAIN;
								end else begin
									waiter_valid_q <= 1'b1;
									waiter_who_q   <= who_q;
									waiter_id_q    <= rid_q;
									waiter_size_q  <= capped_q;
									rep_status_q   <= ST_SUSPENDED;
								end
								state_q <= S_REPLY;
							end else if (n_min == '0) begin
								state_q <= S_REPLY;
							end else begin
								drn_who_q    <= who_q;
								drn_rid_q    <= rid_q;
								n_q          <= n_min;
								rem_q        <= n_min;
								from_write_q <= 1'b0;
								state_q      <= S_RD_ADDR;
							end
						end
						CMD_CANCEL: begin
							if (waiter_valid_q && waiter_who_q == who_q
								&& waiter_id_q == rid_q) begin
								waiter_valid_q <= 1'b0;
								rep_status_q   <= ST_INTR;
							end else begin
								rep_status_q <= ST_STALE;
							end
							state_q <= S_REPLY;
						end
						CMD_SELECT: begin
							rep_kind_q  <= KIND_SEL_READY;
							rep_ready_q <= sel_ready;
							if (ops_q[3] && sel_left != '0) begin
								sel_flags_q <= sel_flags_q | sel_left;
								sel_who_q   <= who_q;
							end
							state_q <= S_REPLY;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_RD_ADDR: begin
					rptr_q  <= ptr_next(rptr_q);
					fill_q  <= fill_q - 1'b1;
					rem_q   <= rem_q - 1'b1;
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (stage_free) begin
						if (rem_q != '0) begin
							state_q <= S_RD_ADDR;
						end else if (from_write_q) begin
							state_q <= S_POST;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_POST: begin
					if (!notice_due) begin
						state_q <= S_REPORT;
					end else if (stage_free) begin
						sel_flags_q[0] <= 1'b0;
						state_q        <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (stage_free) begin
						tally_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_REPLY: begin
					if (stage_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`OLR_NEVER(a_fill_bound, clk, arst_n, fill_q > FILL_W'(LOG_DEPTH),
		"fill count beyond ring depth")
	`OLR_ASSERT(a_rem_below_n, clk, arst_n, (state_q == S_RD_DATA) |-> (rem_q < n_q),
		"drain remainder out of range")
	`OLR_ASSERT(a_waiter_cleared, clk, arst_n,
		(state_q == S_RD_DATA && from_write_q) |-> !waiter_valid_q,
		"served waiter still parked")

endmodule

// ----- rtl/core/overwrite_log_ring_with_waiter.sv -----
// Channel | Handshake            | Beat
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_ready  | cmd data_byte write_end requester req_id
//         |                      | size nonblock ops
// out     | out_valid / out_ready| kind dest reply_id byte_out status count
//         |                      | rdy_bits last
//
// One item at a time under the sequencer in olr_ctrl: a beat is taken in
// the idle state, then executed. A plain write byte then returns to idle; a
// reply item goes on to the reply state. Each drained byte is a ring RAM
// read, then an output push; a write end passes the notice slot, then the
// count report, after draining to the parked reader when it serves one.
// Output stalls hold the sequencer in its push state; reset clears pointers,
// fill count, waiter and select state. The ring RAM itself is not cleared.

`include "assert_macros.svh"

module overwrite_log_ring_with_waiter #(
	parameter int LOG_DEPTH = olr_pkg::LOG_DEPTH_DEF,
	parameter int MAX_READ  = olr_pkg::MAX_READ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic        write_end,
	input  logic [15:0] requester,
	input  logic [31:0] req_id,
	input  logic [15:0] size,
	input  logic        nonblock,
	input  logic [3:0]  ops,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] dest,
	output logic [31:0] reply_id,
	output logic [7:0]  byte_out,
	output logic [2:0]  status,
	output logic [15:0] count,
	output logic [2:0]  rdy_bits,
	output logic        last
);

	import olr_pkg::*;

	localparam int PTR_W = $clog2(LOG_DEPTH);

	item_t              item;
	beat_t              beat;
	beat_t              beat_q;
	logic               out_valid_q;
	logic               stage_free;
	logic               push;
	logic               ram_we;
	logic               ram_re;
	logic [PTR_W-1:0]   ram_waddr;
	logic [PTR_W-1:0]   ram_raddr;
	logic [7:0]         ram_wdata;
	logic [7:0]         ram_rdata;

	assign item.cmd       = cmd_t'(cmd);
	assign item.data_byte = data_byte;
	assign item.write_end = write_end;
	assign item.requester = requester;
	assign item.req_id    = req_id;
	assign item.size      = size;
	assign item.nonblock  = nonblock;
	assign item.ops       = ops;

	// ring storage: one write port, one registered read port
	olr_ram #(
		.DEPTH(LOG_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata_q(ram_rdata)
	);

	olr_ctrl #(
		.LOG_DEPTH(LOG_DEPTH),
		.MAX_READ (MAX_READ)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.item      (item),
		.stage_free(stage_free),
		.push      (push),
		.beat      (beat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// output register: a new beat may load in the cycle the old one leaves
	assign stage_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			beat_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = beat_q.kind;
	assign dest      = beat_q.dest;
	assign reply_id  = beat_q.reply_id;
	assign byte_out  = beat_q.byte_out;
	assign status    = beat_q.status;
	assign count     = beat_q.count;
	assign rdy_bits  = beat_q.rdy_bits;
	assign last      = beat_q.last;

	`OLR_NEVER(a_no_overrun, clk, arst_n, push && out_valid_q && !out_ready,
		"beat pushed over a held beat")
	`OLR_ASSERT(a_hold_stable, clk, arst_n,
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(beat_q)),
		"held beat dropped or changed")
	`OLR_NEVER(a_notice_not_last, clk, arst_n,
		out_valid_q && beat_q.kind == KIND_SEL_NOTICE && beat_q.last,
		"select notice marked last")

endmodule

// ----- bench/tb.sv -----
module tb;
	import olr_pkg::*;

	localparam int unsigned DEPTH    = LOG_DEPTH_DEF;
	localparam int unsigned RD_MAX   = MAX_READ_DEF;
	localparam int          HOLD_LEN = 300;   // long receiver hold-off, in cycles
	localparam int          WATCHDOG = 3000;  // cycles with no beat on either side
	localparam int          CALM_LO  = 700;   // no idling on either side in this window
	localparam int          CALM_HI  = 1300;
	localparam int          RAND_END = 300;   // directed + random call count
	localparam int          WR_LONG  = 24;    // bytes in the closing write call

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic [7:0]  data_byte = '0;
	logic        write_end = 1'b0;
	logic [15:0] requester = '0;
	logic [31:0] req_id = '0;
	logic [15:0] size = '0;
	logic        nonblock = 1'b0;
	logic [3:0]  ops = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [15:0] dest;
	logic [31:0] reply_id;
	logic [7:0]  byte_out;
	logic [2:0]  status;
	logic [15:0] count;
	logic [2:0]  rdy_bits;
	logic        last;

	overwrite_log_ring_with_waiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.data_byte (data_byte),
		.write_end (write_end),
		.requester (requester),
		.req_id    (req_id),
		.size      (size),
		.nonblock  (nonblock),
		.ops       (ops),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.dest      (dest),
		.reply_id  (reply_id),
		.byte_out  (byte_out),
		.status    (status),
		.count     (count),
		.rdy_bits  (rdy_bits),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// calls waiting to be offered, and replies the log owes us, oldest first
	item_t call_q[$];
	beat_t reply_q[$];
	item_t offered;
	int    errors = 0;
	int    cyc = 0;
	int    quiet = 0;

	// ---------------------------------------------------------------
	// Shadow copy of the log ring: updated once per accepted call beat
	// ---------------------------------------------------------------
	logic [7:0]  log_mem [DEPTH];
	int unsigned rd_ptr = 0;
	int unsigned wr_ptr = 0;
	int unsigned fill = 0;
	bit          parked = 1'b0;       // one reader may sleep on an empty ring
	logic [15:0] parked_who = '0;
	logic [31:0] parked_id = '0;
	int unsigned parked_len = 0;
	logic [2:0]  sel_flags = '0;      // select bits still waiting for a notice
	logic [15:0] sel_who = '0;
	int unsigned tally = 0;           // bytes in the open write call, saturating

	function automatic void log_push(kind_t k, logic [15:0] who, logic [31:0] id,
			logic [7:0] b, status_t st, logic [15:0] n, logic [2:0] rdy);
		beat_t e;
		e.kind      = k;
		e.dest      = who;
		e.reply_id  = id;
		e.byte_out  = b;
		e.status    = st;
		e.count     = n;
		e.rdy_bits  = rdy;
		e.last      = 1'b0;
		reply_q.push_back(e);
	endfunction

	// hand out up to want bytes; nothing to give is a single ok status
	function automatic void log_drain(logic [15:0] who, logic [31:0] id, int unsigned want);
		int unsigned n;
		n = (want < fill) ? want : fill;
		if (n == 0) begin
			log_push(KIND_STATUS, who, id, 8'h00, ST_OK, 16'd0, 3'd0);
			return;
		end
		for (int unsigned i = 0; i < n; i++) begin
			log_push(KIND_DATA, who, id, log_mem[rd_ptr], ST_OK, 16'(n), 3'd0);
			rd_ptr = (rd_ptr + 1) % DEPTH;
		end
		fill -= n;
	endfunction

	function automatic void log_apply(item_t it);
		int unsigned n0;
		int unsigned cap;
		logic [2:0]  want;
		logic [2:0]  rdy;
		beat_t       tail;
		n0  = reply_q.size();
		cap = (it.size > RD_MAX) ? RD_MAX : it.size;
		case (it.cmd)
		CMD_WRITE: begin
			log_mem[wr_ptr] = it.data_byte;
			wr_ptr = (wr_ptr + 1) % DEPTH;
			// full ring: the oldest byte is dropped
			if (fill >= DEPTH)
				rd_ptr = (rd_ptr + 1) % DEPTH;
			else
				fill++;
			if (tally < 65535)
				tally++;
			if (it.write_end) begin
				// sleeping reader first, then the read notice, then the byte count
				if (fill > 0 && parked) begin
					log_drain(parked_who, parked_id, parked_len);
					parked = 1'b0;
				end
				if (fill > 0 && sel_flags[0]) begin
					log_push(KIND_SEL_NOTICE, sel_who, 32'd0, 8'h00, ST_OK, 16'd0, 3'b001);
					sel_flags[0] = 1'b0;
				end
				log_push(KIND_STATUS, it.requester, it.req_id, 8'h00, ST_OK, 16'(tally), 3'd0);
				tally = 0;
			end
		end
		CMD_READ: begin
			if (parked) begin
				log_push(KIND_STATUS, it.requester, it.req_id, 8'h00, ST_OK, 16'd0, 3'd0);
			end else if (fill == 0 && cap > 0) begin
				if (it.nonblock) begin
					log_push(KIND_STATUS, it.requester, it.req_id, 8'h00, ST_AGAIN, 16'd0, 3'd0);
				end else begin
					parked     = 1'b1;
					parked_who = it.requester;
					parked_id  = it.req_id;
					parked_len = cap & 6'h3F;
					log_push(KIND_STATUS, it.requester, it.req_id, 8'h00, ST_SUSPENDED,
						16'd0, 3'd0);
				end
			end else begin
				log_drain(it.requester, it.req_id, cap);
			end
		end
		CMD_CANCEL: begin
			if (parked && parked_who == it.requester && parked_id == it.req_id) begin
				parked = 1'b0;
				log_push(KIND_STATUS, it.requester, it.req_id, 8'h00, ST_INTR, 16'd0, 3'd0);
			end else begin
				log_push(KIND_STATUS, it.requester, it.req_id, 8'h00, ST_STALE, 16'd0, 3'd0);
			end
		end
		default: begin
			want = it.ops[2:0];
			rdy  = '0;
			if (want[0] && fill > 0)
				rdy[0] = 1'b1;
			if (want[1])
				rdy[1] = 1'b1;
			want &= ~rdy;
			// notify: remember what was asked for but not ready yet
			if (it.ops[3] && want != 0) begin
				sel_flags |= want;
				sel_who = it.requester;
			end
			log_push(KIND_SEL_READY, it.requester, 32'd0, 8'h00, ST_OK, 16'd0, rdy);
		end
		endcase
		// mark the final reply of this call
		if (reply_q.size() > n0) begin
			tail = reply_q.pop_back();
			tail.last = 1'b1;
			reply_q.push_back(tail);
		end
	endfunction

	// about one cycle in four idles, except inside the calm window
	function automatic bit roll_idle();
		if (cyc >= CALM_LO && cyc < CALM_HI)
			return 1'b0;
		return $urandom_range(99) < 26;
	endfunction

	// a hold-off started now would reach into the calm window
	function automatic bit near_calm();
		return (cyc + HOLD_LEN >= CALM_LO) && (cyc < CALM_HI);
	endfunction

	function automatic int field_chk(string nm, logic [31:0] w, logic [31:0] g);
		if (w !== g) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, nm, w, g);
			return 1;
		end
		return 0;
	endfunction

	// ---------------------------------------------------------------
	// Call side: predicts on acceptance, then offers the next queued call
	// ---------------------------------------------------------------
	always @(posedge clk) begin : drive_p
		item_t nxt;
		bit    free;
		if (arst_n) begin
			free = !in_valid;
			if (in_valid && in_ready) begin
				log_apply(offered);
				free = 1'b1;
			end
			// valid only drops or changes once the current beat is taken
			if (free) begin
				if (call_q.size() > 0 && !roll_idle()) begin
					nxt = call_q.pop_front();
					offered = nxt;
					in_valid  <= 1'b1;
					cmd       <= nxt.cmd;
					data_byte <= nxt.data_byte;
					write_end <= nxt.write_end;
					requester <= nxt.requester;
					req_id    <= nxt.req_id;
					size      <= nxt.size;
					nonblock  <= nxt.nonblock;
					ops       <= nxt.ops;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Reply side: checks each beat against the oldest owed reply.
	// Twice it holds ready low through a hold-off so the block backs up.
	// ---------------------------------------------------------------
	int beats_seen = 0;
	int hold_left = 0;
	int holds_done = 0;

	always @(posedge clk) begin : watch_p
		beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				beats_seen++;
				if (reply_q.size() == 0) begin
					errors++;
					$display("%0t: reply beat with nothing owed: kind %0h dest %0h id %0h",
						$time, kind, dest, reply_id);
				end else begin
					want = reply_q.pop_front();
					errors += field_chk("kind", want.kind, kind);
					errors += field_chk("dest", want.dest, dest);
					errors += field_chk("reply_id", want.reply_id, reply_id);
					errors += field_chk("byte_out", want.byte_out, byte_out);
					errors += field_chk("status", want.status, status);
					errors += field_chk("count", want.count, count);
					errors += field_chk("rdy_bits", want.rdy_bits, rdy_bits);
					errors += field_chk("last", want.last, last);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_done < 2 && beats_seen >= (holds_done == 0 ? 60 : 300)
					&& !near_calm()) begin
				holds_done++;
				hold_left = HOLD_LEN - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !roll_idle();
			end
		end
	end

	// watchdog: ends the run when neither side has moved a beat for too long
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else if (quiet >= WATCHDOG) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Call builders
	// ---------------------------------------------------------------
	function automatic item_t mk(cmd_t c, logic [7:0] d, bit we, logic [15:0] who,
			logic [31:0] id, logic [15:0] sz, bit nb, logic [3:0] op);
		item_t it;
		it.cmd       = c;
		it.data_byte = d;
		it.write_end = we;
		it.requester = who;
		it.req_id    = id;
		it.size      = sz;
		it.nonblock  = nb;
		it.ops       = op;
		return it;
	endfunction

	// every field random; unused fields toggle too
	function automatic item_t rand_item(cmd_t c);
		return mk(c, 8'($urandom), 1'($urandom), 16'($urandom), $urandom,
			16'($urandom), 1'($urandom), 4'($urandom));
	endfunction

	function automatic logic [15:0] rand_size();
		case ($urandom_range(3))
		0:       return 16'd0;
		1:       return 16'($urandom_range(1, 40));
		2:       return 16'($urandom);
		default: return 16'($urandom_range(31, 33));
		endcase
	endfunction

	int n_calls = 0;

	function automatic void send(item_t it);
		call_q.push_back(it);
		n_calls++;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------
	initial begin : stim_p
		item_t       it;
		int          pick;
		int          len;
		int unsigned drains;
		logic [15:0] who;
		logic [31:0] id;

		// directed: empty ring, the sleeping reader, cancels, select and notice
		send(mk(CMD_READ, 8'h00, 1'b0, 16'h0010, 32'h1, 16'd5, 1'b1, 4'h0));       // try again
		send(mk(CMD_READ, 8'h00, 1'b0, 16'h0011, 32'h2, 16'd0, 1'b0, 4'h0));       // zero size
		send(mk(CMD_SELECT, 8'h00, 1'b0, 16'h0001, 32'h0, 16'd0, 1'b0, 4'hF));     // register
		send(mk(CMD_CANCEL, 8'h00, 1'b0, 16'h0000, 32'h0, 16'd0, 1'b0, 4'h0));     // no sleeper
		send(mk(CMD_READ, 8'h00, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 4'h0)); // sleeps
		send(mk(CMD_READ, 8'h00, 1'b0, 16'h0002, 32'h3, 16'd1, 1'b0, 4'h0));       // sleeper busy
		send(mk(CMD_CANCEL, 8'h00, 1'b0, 16'hFFFF, 32'hFFFF_FFFE, 16'd0, 1'b0, 4'h0)); // wrong id
		send(mk(CMD_CANCEL, 8'h00, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 1'b0, 4'h0)); // match
		send(mk(CMD_READ, 8'h00, 1'b0, 16'h1234, 32'hCAFE_0001, 16'd2, 1'b0, 4'h0)); // sleeps, 2
		send(mk(CMD_WRITE, 8'h00, 1'b0, 16'h0000, 32'h0, 16'd0, 1'b0, 4'h0));
		send(mk(CMD_WRITE, 8'hFF, 1'b0, 16'h0000, 32'h0, 16'd0, 1'b0, 4'h0));
		send(mk(CMD_WRITE, 8'hA5, 1'b1, 16'h00AA, 32'h55, 16'd0, 1'b0, 4'h0));     // serve + notice
		send(mk(CMD_SELECT, 8'h00, 1'b0, 16'h0003, 32'h0, 16'd0, 1'b0, 4'h1));     // read ready
		send(mk(CMD_READ, 8'h00, 1'b0, 16'h0004, 32'h4, 16'd40, 1'b1, 4'h0));      // short drain
		send(mk(CMD_SELECT, 8'h00, 1'b0, 16'h0005, 32'h0, 16'd0, 1'b0, 4'h8));     // notify, no bits
		send(mk(CMD_SELECT, 8'h00, 1'b0, 16'h0006, 32'h0, 16'd0, 1'b0, 4'h9));     // notify on read
		send(mk(CMD_READ, 8'h00, 1'b0, 16'h0007, 32'h7, 16'd32, 1'b0, 4'h0));      // sleeps, 32
		send(mk(CMD_WRITE, 8'h5A, 1'b0, 16'h0000, 32'h0, 16'd0, 1'b0, 4'h0));
		send(mk(CMD_WRITE, 8'hC3, 1'b1, 16'h0008, 32'h8, 16'd0, 1'b0, 4'h0));      // ring empties
		send(mk(CMD_WRITE, 8'h7E, 1'b1, 16'h0009, 32'h9, 16'd0, 1'b0, 4'h0));      // report + notice
		send(mk(CMD_READ, 8'h00, 1'b0, 16'h000A, 32'hA, 16'd1, 1'b1, 4'h0));
		send(mk(CMD_SELECT, 8'h00, 1'b0, 16'h000B, 32'h0, 16'd0, 1'b0, 4'h6));     // write + error

		// random: mostly well-formed write calls, reads, read/cancel pairs, selects
		who = 16'h0;
		id  = 32'h0;
		while (n_calls < RAND_END) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				len = $urandom_range(1, 8);
				for (int j = 0; j < len; j++) begin
					it = rand_item(CMD_WRITE);
					it.write_end = (j == len - 1);
					send(it);
				end
			end else if (pick < 60) begin
				it = rand_item(CMD_READ);
				it.size = rand_size();
				send(it);
				who = it.requester;
				id  = it.req_id;
			end else if (pick < 70) begin
				// blocking read then its cancel, sometimes with a write call between
				it = rand_item(CMD_READ);
				it.nonblock = 1'b0;
				it.size = 16'($urandom_range(1, 40));
				send(it);
				who = it.requester;
				id  = it.req_id;
				if ($urandom_range(1)) begin
					it = rand_item(CMD_WRITE);
					it.write_end = 1'b1;
					send(it);
				end
				it = rand_item(CMD_CANCEL);
				it.requester = who;
				it.req_id = id;
				send(it);
			end else if (pick < 78) begin
				it = rand_item(CMD_CANCEL);
				if ($urandom_range(1)) begin
					it.requester = who;
					it.req_id = id;
				end
				send(it);
			end else if (pick < 88) begin
				send(rand_item(CMD_SELECT));
			end else begin
				send(rand_item(cmd_t'($urandom_range(3))));
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// sender pauses until every owed reply is in
		while (call_q.size() != 0 || in_valid || reply_q.size() != 0)
			@(posedge clk);

		// empty the ring, park a reader, arm the notice, then one long write
		// call that wakes the reader and fires the notice
		if (parked)
			send(mk(CMD_CANCEL, 8'h00, 1'b0, parked_who, parked_id, 16'd0, 1'b0, 4'h0));
		drains = (fill + RD_MAX - 1) / RD_MAX;
		for (int unsigned j = 0; j < drains; j++)
			send(mk(CMD_READ, 8'h00, 1'b0, 16'h0C00, j, 16'(RD_MAX), 1'b1, 4'h0));
		send(mk(CMD_READ, 8'h00, 1'b0, 16'hBEEF, 32'hD00D_0001, 16'd20, 1'b0, 4'h0));
		send(mk(CMD_SELECT, 8'h00, 1'b0, 16'h0F0F, 32'h0, 16'd0, 1'b0, 4'h9));
		for (int j = 0; j < WR_LONG; j++) begin
			it = rand_item(CMD_WRITE);
			it.write_end = (j == WR_LONG - 1);
			send(it);
		end
		for (int j = 0; j < 4; j++)
			send(mk(CMD_READ, 8'h00, 1'b0, 16'h0D00, j, 16'd32, 1'b1, 4'h0));
		send(mk(CMD_READ, 8'h00, 1'b0, 16'h0D10, 32'h10, 16'hFFFF, 1'b0, 4'h0));
		send(mk(CMD_SELECT, 8'h00, 1'b0, 16'h0D11, 32'h0, 16'd0, 1'b0, 4'hF));

		while (call_q.size() != 0 || in_valid || reply_q.size() != 0)
			@(posedge clk);
		// let any stray beat show up before the verdict
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
